FILE: design/rice_decoder_32bit_top_macros.svh
// Assertion macros used by the Rice decoder RTL.
// Depends on nothing; included by rd32_back, the only module that carries assertions.
`ifndef RICE_DECODER_32BIT_TOP_MACROS_SVH
`define RICE_DECODER_32BIT_TOP_MACROS_SVH

// Implication checked in the same cycle, disabled during reset.
`define RD32_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rice decoder check failed");

// Implication checked in the cycle after the antecedent.
`define RD32_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rice decoder check failed");

`endif

FILE: design/rd32_pkg.sv
// Shared types, constants and helper functions of the Rice decoder.
// Depends on nothing; imported by every module of the block.
package rd32_pkg;

  localparam int unsigned MaxTilePixels = 1048576;
  localparam int unsigned CodeBits      = 5;
  localparam int unsigned RawCode       = 26;
  localparam int unsigned PixBits       = 32;
  localparam int unsigned BufBits       = 40;
  localparam int unsigned ResCap        = 64;
  localparam int unsigned BlockMax      = 64;
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned QueuePtrW     = $clog2(QueueDepth);

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        tile_first;
    logic        tile_end;
    logic [20:0] tile_pixels;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic        pixel_valid;
    logic        run_last;
    logic        tile_done;
    logic        short_stream;
  } out_item_t;

  // Low-ones mask over the bit buffer width.
  function automatic logic [39:0] mask40(input logic [5:0] k);
    logic [39:0] m;
    if (k >= 6'(BufBits)) begin
      m = '1;
    end else begin
      m = (40'd1 << k) - 40'd1;
    end
    return m;
  endfunction

  // Maps the folded difference back to a two's complement value.
  function automatic logic [31:0] unzig(input logic [31:0] d);
    logic [31:0] h;
    h = d >> 1;
    return d[0] ? ~h : h;
  endfunction

endpackage

FILE: design/rd32_front.sv
// Front stage: registers each incoming byte request and clamps the tile size.
// Depends on rd32_pkg; feeds rd32_queue.
module rd32_front #(
  parameter int unsigned MAX_TILE_PIXELS = rd32_pkg::MaxTilePixels
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               strm_valid,
  output logic               strm_stall,
  input  rd32_pkg::in_item_t strm_data,
  output logic               cmd_valid,
  input  logic               cmd_full,
  output rd32_pkg::in_item_t cmd_data
);
  import rd32_pkg::*;

  localparam logic [24:0] MaxW = 25'(MAX_TILE_PIXELS);

  logic     hold_valid;
  in_item_t hold;
  in_item_t clamped;
  logic     accept;

  assign strm_stall = hold_valid && cmd_full;
  assign accept     = strm_valid && !strm_stall;
  assign cmd_valid  = hold_valid;
  assign cmd_data   = hold;

  always_comb begin
    clamped = strm_data;
    if ({4'd0, strm_data.tile_pixels} > MaxW) begin
      clamped.tile_pixels = MaxW[20:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (!cmd_full) begin
      hold_valid <= 1'b0;
    end
    if (accept) begin
      hold <= clamped;
    end
  end

endmodule

FILE: design/rd32_queue.sv
// Short request queue between the front stage and the decode sequencer.
// Depends on rd32_pkg.
module rd32_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rd32_pkg::in_item_t push_data,
  output logic               full,
  output logic               not_empty,
  input  logic               pop,
  output rd32_pkg::in_item_t pop_data
);
  import rd32_pkg::*;

  in_item_t               slots [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr;
  logic [QueuePtrW-1:0]   rd_ptr;
  logic [QueuePtrW:0]     count;
  logic                   do_push;
  logic                   do_pop;

  assign full      = (count == (QueuePtrW + 1)'(QueueDepth));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: design/rd32_back.sv
// Decode sequencer: runs the bit buffer, split codes and Rice decoding per request.
// Depends on rd32_pkg and the assertion macro header.
`include "rice_decoder_32bit_top_macros.svh"
module rd32_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  rd32_pkg::in_item_t  q_data,
  output logic                q_pop,
  input  logic [6:0]          block_size,
  output logic                pix_valid,
  input  logic                pix_stall,
  output rd32_pkg::out_item_t pix_data
);
  import rd32_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER, PH_CODE, PH_RUN, PH_RAW, PH_UNARY, PH_LOW, PH_IDLE
  } phase_t;

  typedef enum logic [2:0] {
    S_FETCH, S_RUN1, S_APPEND, S_RUN2, S_END, S_FLUSH
  } state_t;

  state_t      state;
  phase_t      phase;
  logic [39:0] bit_buffer;
  logic [5:0]  bits_held;
  logic [31:0] last_pixel;
  logic [2:0]  header_bytes_seen;
  logic [20:0] pixels_done;
  logic [20:0] tile_pixel_total;
  logic [6:0]  block_remaining;
  logic [4:0]  split_code;
  logic [31:0] zero_count;
  logic        stream_ended;
  logic [6:0]  n_res;
  logic        starved;
  logic        cur_end;
  logic [7:0]  cur_byte;
  logic        pend_v;
  out_item_t   pend;
  logic        out_valid;
  out_item_t   out_data;

  logic        out_free;
  logic        can_emit;
  logic [5:0]  take_k;
  logic [31:0] take_v;
  logic [5:0]  rest_held;
  logic [39:0] rest_buf;
  logic [4:0]  fs;
  logic        it_ret;
  logic        it_starved;
  logic        it_emit;
  logic [31:0] emit_val;
  logic [31:0] low_d;
  logic [20:0] done_inc;
  logic [6:0]  br_dec;
  logic        fin;
  logic [6:0]  bs_eff;
  logic [20:0] left;
  logic [6:0]  br_new;
  logic [20:0] eff_total;
  phase_t      eff_phase;
  logic        eff_ended;
  logic [31:0] eff_last;
  logic [2:0]  eff_hdr;
  logic [2:0]  hdr_inc;
  logic        ended_new;
  out_item_t   new_pix;
  out_item_t   err_res;

  assign out_free = !out_valid || !pix_stall;
  assign can_emit = !pend_v || out_free;
  assign q_pop    = (state == S_FETCH) && q_valid;
  assign pix_valid = out_valid;
  assign pix_data  = out_data;

  // Values as seen after a tile start on the request being fetched.
  assign eff_total = q_data.tile_first ? q_data.tile_pixels : tile_pixel_total;
  assign eff_phase = q_data.tile_first ? PH_HEADER : phase;
  assign eff_ended = q_data.tile_first ? 1'b0 : stream_ended;
  assign eff_last  = q_data.tile_first ? 32'd0 : last_pixel;
  assign eff_hdr   = q_data.tile_first ? 3'd0 : header_bytes_seen;
  assign hdr_inc   = eff_hdr + 3'd1;
  assign ended_new = stream_ended || cur_end;

  always_comb begin
    fs = split_code - 5'd1;
    unique case (phase)
      PH_CODE:  take_k = 6'(CodeBits);
      PH_RAW:   take_k = 6'(PixBits);
      PH_UNARY: take_k = 6'd1;
      PH_LOW:   take_k = {1'b0, fs};
      default:  take_k = 6'd0;
    endcase
    take_v    = 32'((bit_buffer >> (bits_held - take_k)) & mask40(take_k));
    rest_held = bits_held - take_k;
    rest_buf  = bit_buffer & mask40(rest_held);
    low_d     = (zero_count << fs) | take_v;

    done_inc = pixels_done + 21'd1;
    br_dec   = (block_remaining != 7'd0) ? block_remaining - 7'd1 : 7'd0;
    fin      = (done_inc >= tile_pixel_total);

    if (block_size == 7'd0) begin
      bs_eff = 7'd1;
    end else if (block_size > 7'(BlockMax)) begin
      bs_eff = 7'(BlockMax);
    end else begin
      bs_eff = block_size;
    end
    left   = tile_pixel_total - pixels_done;
    br_new = ({14'd0, bs_eff} < left) ? bs_eff : left[6:0];

    it_ret     = 1'b0;
    it_starved = 1'b0;
    it_emit    = 1'b0;
    emit_val   = last_pixel;
    if (n_res >= 7'(ResCap)) begin
      it_ret = 1'b1;
    end else begin
      unique case (phase)
        PH_CODE: begin
          if (bits_held < 6'(CodeBits)) begin
            it_ret     = 1'b1;
            it_starved = 1'b1;
          end
        end
        PH_RUN: begin
          it_emit = 1'b1;
        end
        PH_RAW: begin
          if (bits_held < 6'(PixBits)) begin
            it_ret     = 1'b1;
            it_starved = 1'b1;
          end else begin
            it_emit  = 1'b1;
            emit_val = last_pixel + unzig(take_v);
          end
        end
        PH_UNARY: begin
          if (bits_held == 6'd0) begin
            it_ret     = 1'b1;
            it_starved = 1'b1;
          end
        end
        PH_LOW: begin
          if (bits_held < {1'b0, fs}) begin
            it_ret     = 1'b1;
            it_starved = 1'b1;
          end else begin
            it_emit  = 1'b1;
            emit_val = last_pixel + unzig(low_d);
          end
        end
        PH_HEADER: begin
          it_ret     = 1'b1;
          it_starved = 1'b1;
        end
        default: begin
          it_ret = 1'b1;
        end
      endcase
    end

    new_pix.pixel_value  = emit_val;
    new_pix.pixel_valid  = 1'b1;
    new_pix.run_last     = 1'b0;
    new_pix.tile_done    = fin;
    new_pix.short_stream = 1'b0;

    err_res.pixel_value  = 32'd0;
    err_res.pixel_valid  = 1'b0;
    err_res.run_last     = 1'b0;
    err_res.tile_done    = 1'b0;
    err_res.short_stream = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_FETCH;
      phase             <= PH_HEADER;
      bit_buffer        <= '0;
      bits_held         <= '0;
      last_pixel        <= '0;
      header_bytes_seen <= '0;
      pixels_done       <= '0;
      tile_pixel_total  <= '0;
      block_remaining   <= '0;
      split_code        <= '0;
      zero_count        <= '0;
      stream_ended      <= 1'b0;
      n_res             <= '0;
      starved           <= 1'b0;
      pend_v            <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (out_valid && !pix_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_FETCH: begin
          if (q_valid) begin
            cur_end  <= q_data.tile_end;
            cur_byte <= q_data.data_byte;
            n_res    <= '0;
            starved  <= 1'b0;
            if (q_data.tile_first) begin
              bit_buffer        <= '0;
              bits_held         <= '0;
              last_pixel        <= '0;
              header_bytes_seen <= '0;
              pixels_done       <= '0;
              block_remaining   <= '0;
              split_code        <= '0;
              zero_count        <= '0;
              stream_ended      <= 1'b0;
              phase             <= PH_HEADER;
              tile_pixel_total  <= q_data.tile_pixels;
            end
            if (eff_total == 21'd0 || eff_phase == PH_IDLE) begin
              state <= S_FETCH;
            end else if (eff_ended) begin
              state <= S_RUN2;
            end else if (eff_phase == PH_HEADER) begin
              last_pixel        <= {eff_last[23:0], q_data.data_byte};
              header_bytes_seen <= hdr_inc;
              if (hdr_inc >= 3'd4) begin
                phase <= PH_CODE;
              end
              state <= S_RUN2;
            end else begin
              state <= S_RUN1;
            end
          end
        end
        S_RUN1, S_RUN2: begin
          if (it_ret) begin
            if (state == S_RUN1) begin
              state <= S_APPEND;
            end else begin
              starved <= it_starved;
              state   <= S_END;
            end
          end else if (it_emit) begin
            if (can_emit) begin
              bits_held       <= rest_held;
              bit_buffer      <= rest_buf;
              last_pixel      <= emit_val;
              pixels_done     <= done_inc;
              block_remaining <= br_dec;
              if (fin) begin
                phase <= PH_IDLE;
              end else if (br_dec == 7'd0) begin
                phase <= PH_CODE;
              end else if (phase == PH_LOW) begin
                phase      <= PH_UNARY;
                zero_count <= '0;
              end
              if (pend_v) begin
                out_valid <= 1'b1;
                out_data  <= pend;
              end
              pend   <= new_pix;
              pend_v <= 1'b1;
              n_res  <= n_res + 7'd1;
            end
          end else begin
            bits_held  <= rest_held;
            bit_buffer <= rest_buf;
            if (phase == PH_CODE) begin
              split_code      <= take_v[4:0];
              block_remaining <= br_new;
              if (take_v[4:0] == 5'd0) begin
                phase <= PH_RUN;
              end else if (take_v[4:0] == 5'(RawCode)) begin
                phase <= PH_RAW;
              end else begin
                phase      <= PH_UNARY;
                zero_count <= '0;
              end
            end else if (take_v[0]) begin
              phase <= PH_LOW;
            end else begin
              zero_count <= zero_count + 32'd1;
            end
          end
        end
        S_APPEND: begin
          // A byte that finds more than 32 bits held is dropped.
          if (bits_held <= 6'd32) begin
            bit_buffer <= {bit_buffer[31:0], cur_byte};
            bits_held  <= bits_held + 6'd8;
          end
          state <= S_RUN2;
        end
        S_END: begin
          stream_ended <= ended_new;
          if (ended_new && starved && phase != PH_IDLE && n_res < 7'(ResCap)) begin
            if (can_emit) begin
              if (pend_v) begin
                out_valid <= 1'b1;
                out_data  <= pend;
              end
              pend   <= err_res;
              pend_v <= 1'b1;
              n_res  <= n_res + 7'd1;
              phase  <= PH_IDLE;
              state  <= S_FLUSH;
            end
          end else begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!pend_v) begin
            state <= S_FETCH;
          end else if (out_free) begin
            out_valid         <= 1'b1;
            out_data          <= pend;
            out_data.run_last <= 1'b1;
            pend_v            <= 1'b0;
            state             <= S_FETCH;
          end
        end
        default: begin
          state <= S_FETCH;
        end
      endcase
    end
  end

  `RD32_ASSERT_NOW(a_fetch_no_pend, clk, rst, state == S_FETCH, !pend_v)
  `RD32_ASSERT_NOW(a_held_bound, clk, rst, 1'b1, bits_held <= 6'(BufBits))
  `RD32_ASSERT_NOW(a_res_cap, clk, rst, 1'b1, n_res <= 7'(ResCap))
  `RD32_ASSERT_NEXT(a_flush_done, clk, rst, state == S_FLUSH && out_free,
                    state == S_FETCH)

endmodule

FILE: design/rice_decoder_32bit_top.sv
// Top level of the Rice decoder for 32-bit pixel tiles, with its register port.
// Depends on rd32_pkg, rd32_front, rd32_queue and rd32_back.
//
// Usage: compressed tile bytes arrive one request at a time on strm_valid /
// strm_stall / strm_data; a request is taken at a clock edge with strm_valid
// high and strm_stall low. Set tile_first on the first byte of a tile, with
// tile_pixels giving its size, and tile_end on its last byte. Decoded pixels
// leave on pix_valid / pix_stall / pix_data, one request per pixel, with
// run_last on the last result caused by a byte, tile_done on the final pixel
// and a short_stream result if the bytes run out early.
// A byte passes the front register and a four-entry queue before the sequencer
// pops it. Each result waits in a pending register: the last one of a byte
// leaves in the flush state, an earlier one once the next pixel is decoded.
// The run state takes a split code, unary bit or pixel per step. A data byte
// passes the fetch, run, append, run, end and flush states; a header byte skips
// the first run and the append. Up to 64 pixels follow from one byte.
// When the receiver stalls, the output holds and the sequencer waits; the
// queue then fills and strm_stall rises. Reset (rst, synchronous) empties the
// queue, clears decoder state and sets block_size to 32. block_size is
// written at APB byte address 0 and must only change while the block is idle.
module rice_decoder_32bit_top #(
  parameter int unsigned MAX_TILE_PIXELS = rd32_pkg::MaxTilePixels
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                strm_valid,
  output logic                strm_stall,
  input  rd32_pkg::in_item_t  strm_data,
  output logic                pix_valid,
  input  logic                pix_stall,
  output rd32_pkg::out_item_t pix_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import rd32_pkg::*;

  logic       block_size_wr;
  logic [6:0] block_size;
  logic       cmd_valid;
  logic       cmd_full;
  in_item_t   cmd_data;
  logic       q_valid;
  logic       q_pop;
  in_item_t   q_data;

  // Register 0 (block_size) sits at byte address 0; address 4 holds nothing.
  assign pready        = 1'b1;
  assign block_size_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata        = paddr[2] ? 32'd0 : {25'd0, block_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= 7'd32;
    end else if (block_size_wr) begin
      block_size <= pwdata[6:0];
    end
  end

  rd32_front #(
    .MAX_TILE_PIXELS(MAX_TILE_PIXELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .strm_valid (strm_valid),
    .strm_stall (strm_stall),
    .strm_data  (strm_data),
    .cmd_valid  (cmd_valid),
    .cmd_full   (cmd_full),
    .cmd_data   (cmd_data)
  );

  rd32_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_valid),
    .push_data (cmd_data),
    .full      (cmd_full),
    .not_empty (q_valid),
    .pop       (q_pop),
    .pop_data  (q_data)
  );

  rd32_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .block_size (block_size),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pix_data   (pix_data)
  );

endmodule

FILE: sim/tb_rice_decoder_32bit_top.sv
// Self-checking testbench for the Rice decoder top level (32-bit pixel tiles).
// Depends on rd32_pkg and rice_decoder_32bit_top; holds its own decoder predictor.
`timescale 1ns / 100ps

module tb_rice_decoder_32bit_top;
  import rd32_pkg::*;

  // Decoder phases of the predictor, one per kind of work the sequencer does.
  typedef enum logic [2:0] {
    PH_HDR, PH_SPLIT, PH_REPEAT, PH_RAW32, PH_UNARY, PH_LOWBITS, PH_DONE
  } dec_phase_e;

  localparam logic [2:0] AddrBlockSize = 3'd0;
  localparam int unsigned WatchLimit   = 5000;
  localparam int unsigned DrainCycles  = 200;

  // The scoreboard holds a bit-exact copy of the decoder state. Each accepted
  // request is run through it, and the pixels it yields wait in a queue until
  // the block hands out its results.
  class pixel_scoreboard;
    int unsigned bsize;
    logic [63:0] bitbuf;
    int unsigned held, hdr, done, total, remain, code, zeros, n_out, errors;
    logic [31:0] last;
    bit          ended;
    dec_phase_e  phase;
    out_item_t   pending[$];

    function new();
      errors = 0;
      bsize  = 32;
      total  = 0;
      clear_tile();
    endfunction

    function void clear_tile();
      bitbuf = '0;
      held   = 0;
      last   = '0;
      hdr    = 0;
      done   = 0;
      remain = 0;
      code   = 0;
      zeros  = 0;
      ended  = 0;
      phase  = PH_HDR;
    endfunction

    function logic [63:0] ones(int unsigned k);
      return (k >= 64) ? '1 : ((64'd1 << k) - 64'd1);
    endfunction

    function logic [31:0] take(int unsigned k);
      logic [31:0] v;
      v = 32'((bitbuf >> (held - k)) & ones(k));
      held -= k;
      bitbuf &= ones(held);
      return v;
    endfunction

    function logic [31:0] unfold(logic [31:0] d);
      return d[0] ? ~(d >> 1) : (d >> 1);
    endfunction

    function void emit(logic [31:0] v);
      out_item_t r;
      last = v;
      done++;
      if (remain > 0) remain--;
      r = '0;
      r.pixel_value = v;
      r.pixel_valid = 1'b1;
      r.tile_done   = (done >= total);
      pending.push_back(r);
      n_out++;
      if (r.tile_done) phase = PH_DONE;
      else if (remain == 0) phase = PH_SPLIT;
      else if (phase == PH_LOWBITS) begin
        phase = PH_UNARY;
        zeros = 0;
      end
    endfunction

    // Runs the decoder until it starves, finishes or hits the per-byte cap.
    // Returns 1 when it stopped for lack of bits.
    function bit decode();
      int unsigned bs, left, fs;
      logic [31:0] d, zz;
      while (n_out < ResCap) begin
        case (phase)
          PH_SPLIT: begin
            if (held < CodeBits) return 1'b1;
            code = take(CodeBits);
            bs = (bsize == 0) ? 1 : ((bsize > BlockMax) ? BlockMax : bsize);
            left = total - done;
            remain = (bs < left) ? bs : left;
            if (code == 0) phase = PH_REPEAT;
            else if (code == RawCode) phase = PH_RAW32;
            else begin
              phase = PH_UNARY;
              zeros = 0;
            end
          end
          PH_REPEAT: emit(last);
          PH_RAW32: begin
            if (held < PixBits) return 1'b1;
            d = take(PixBits);
            emit(last + unfold(d));
          end
          PH_UNARY: begin
            if (held == 0) return 1'b1;
            if (take(1) != 0) phase = PH_LOWBITS;
            else zeros++;
          end
          PH_LOWBITS: begin
            fs = (code - 1) & 31;
            if (held < fs) return 1'b1;
            zz = zeros;
            d = (zz << fs) | take(fs);
            emit(last + unfold(d));
          end
          PH_HDR: return 1'b1;
          default: return 1'b0;
        endcase
      end
      return 1'b0;
    endfunction

    function void note_request(in_item_t it);
      bit starved;
      out_item_t r;
      n_out = 0;
      starved = 0;
      if (it.tile_first) begin
        clear_tile();
        total = (it.tile_pixels > MaxTilePixels) ? MaxTilePixels : it.tile_pixels;
      end
      if (total == 0 || phase == PH_DONE) return;
      if (ended) begin
        starved = decode();
      end else if (phase == PH_HDR) begin
        last = {last[23:0], it.data_byte};
        hdr++;
        if (hdr >= 4) phase = PH_SPLIT;
        starved = decode();
      end else begin
        void'(decode());
        // A byte that finds the buffer too full is lost.
        if (held + 8 <= BufBits) begin
          bitbuf = ((bitbuf << 8) | it.data_byte) & ones(BufBits);
          held += 8;
        end
        starved = decode();
      end
      if (it.tile_end) ended = 1;
      if (ended && starved && phase != PH_DONE && n_out < ResCap) begin
        r = '0;
        r.short_stream = 1'b1;
        pending.push_back(r);
        n_out++;
        phase = PH_DONE;
      end
      if (n_out > 0) begin
        r = pending.pop_back();
        r.run_last = 1'b1;
        pending.push_back(r);
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_pixel(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report("unexpected result, value", got.pixel_value, 0);
        return;
      end
      want = pending.pop_front();
      if (got.pixel_value != want.pixel_value)
        report("pixel_value", got.pixel_value, want.pixel_value);
      if (got.pixel_valid != want.pixel_valid)
        report("pixel_valid", got.pixel_valid, want.pixel_valid);
      if (got.run_last != want.run_last)
        report("run_last", got.run_last, want.run_last);
      if (got.tile_done != want.tile_done)
        report("tile_done", got.tile_done, want.tile_done);
      if (got.short_stream != want.short_stream)
        report("short_stream", got.short_stream, want.short_stream);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        strm_valid = 1'b0;
  logic        strm_stall;
  in_item_t    strm_data = '0;
  logic        pix_valid;
  logic        pix_stall = 1'b0;
  out_item_t   pix_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pixel_scoreboard sb = new();
  int unsigned quiet_cycles = 0;
  int unsigned bytes_sent = 0;
  bit          sender_busy = 0;
  int unsigned stall_left = 0;
  int unsigned calm_left = 0;

  rice_decoder_32bit_top i_dut (
    .clk(clk), .rst(rst),
    .strm_valid(strm_valid), .strm_stall(strm_stall), .strm_data(strm_data),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix_data(pix_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Output side: results are checked at the edge that accepts them. The stall
  // pattern alternates stretches of random stalls with stretches of none.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (pix_valid && !pix_stall) begin
        sb.check_pixel(pix_data);
        quiet_cycles = 0;
      end else if (!(strm_valid && !strm_stall)) begin
        quiet_cycles++;
      end else begin
        quiet_cycles = 0;
      end
      if (quiet_cycles >= WatchLimit) begin
        $display("watchdog: no request accepted for %0d cycles", WatchLimit);
        $display("tb_rice_decoder_32bit_top: FAIL");
        $finish;
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      pix_stall <= 1'b1;
    end else if (calm_left > 0) begin
      calm_left--;
      pix_stall <= 1'b0;
    end else if ($urandom_range(9) == 0) begin
      calm_left = $urandom_range(80, 20);
      pix_stall <= 1'b0;
    end else begin
      stall_left = pick_gap();
      pix_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Offers one request and returns at the edge that takes it, after the
  // predictor has seen it. An idle gap may go before the request.
  task automatic send_request(in_item_t it);
    int unsigned g;
    g = sender_busy ? 0 : pick_gap();
    if (g > 0) begin
      strm_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    strm_valid <= 1'b1;
    strm_data  <= it;
    do @(posedge clk); while (strm_stall);
    sb.note_request(it);
    bytes_sent++;
  endtask

  // Holds the input off until every predicted result has come out, then lets
  // bytes that caused no result leave the pipeline as well.
  task automatic drain();
    strm_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // pready is tied high, so the register takes the value at this edge.
    sb.bsize = value & 32'h7F;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic put_bits(ref bit bits[$], input logic [31:0] v, input int unsigned k);
    for (int i = int'(k) - 1; i >= 0; i--) bits.push_back(v[i]);
  endtask

  // Encodes a well-formed tile with random content. A forced split code of -1
  // lets every block pick its own code.
  task automatic build_tile(int unsigned npix, int force_code, ref logic [7:0] stream[$]);
    bit bits[$];
    int unsigned rem, blk, bs, c, z, fs;
    logic [7:0] b;
    bs = (sb.bsize == 0) ? 1 : ((sb.bsize > BlockMax) ? BlockMax : sb.bsize);
    put_bits(bits, $urandom(), 32);
    rem = npix;
    while (rem > 0) begin
      blk = (bs < rem) ? bs : rem;
      if (force_code >= 0) c = force_code;
      else begin
        case ($urandom_range(9))
          0: c = 0;
          1: c = RawCode;
          2: c = $urandom_range(31, 27);
          default: c = $urandom_range(25, 1);
        endcase
      end
      put_bits(bits, c, CodeBits);
      if (c == RawCode) begin
        for (int i = 0; i < int'(blk); i++) put_bits(bits, $urandom(), 32);
      end else if (c != 0) begin
        fs = (c - 1) & 31;
        for (int i = 0; i < int'(blk); i++) begin
          z = ($urandom_range(15) == 0) ? $urandom_range(20) : $urandom_range(3);
          repeat (z) bits.push_back(1'b0);
          bits.push_back(1'b1);
          put_bits(bits, $urandom(), fs);
        end
      end
      rem -= blk;
    end
    while (bits.size() % 8 != 0) bits.push_back(1'($urandom_range(1)));
    stream.delete();
    while (bits.size() > 0) begin
      for (int i = 0; i < 8; i++) b[7 - i] = bits.pop_front();
      stream.push_back(b);
    end
  endtask

  // Sends a byte stream as one tile; extra trailing bytes follow tile_end.
  task automatic send_tile(logic [7:0] stream[$], logic [20:0] npix, int unsigned trail);
    in_item_t it;
    foreach (stream[i]) begin
      it.data_byte   = stream[i];
      it.tile_first  = (i == 0);
      it.tile_end    = (i == stream.size() - 1);
      it.tile_pixels = (i == 0) ? npix : 21'($urandom());
      send_request(it);
    end
    repeat (trail) begin
      it = in_item_t'(31'($urandom()));
      it.tile_first = 1'b0;
      send_request(it);
    end
  endtask

  task automatic send_random_tile();
    logic [7:0] stream[$];
    int unsigned npix, r;
    r = $urandom_range(99);
    npix = ($urandom_range(9) == 0) ? $urandom_range(100, 25) : $urandom_range(24, 1);
    if (r < 10) begin
      // Noise: random bytes with random framing bits.
      repeat ($urandom_range(10, 3)) stream.push_back(8'($urandom()));
      send_tile(stream, 21'($urandom()), $urandom_range(3));
    end else begin
      build_tile(npix, -1, stream);
      // Some streams are cut short so the decoder runs out of bytes.
      if (r < 25 && stream.size() > 1) begin
        repeat ($urandom_range(stream.size() - 1, 1)) void'(stream.pop_back());
      end
      send_tile(stream, 21'(npix), (r >= 80) ? $urandom_range(4, 1) : 0);
    end
  endtask

  initial begin
    logic [7:0] stream[$];
    in_item_t it;
    logic [31:0] sizes[$];
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Bytes before any tile and a tile of zero pixels are ignored.
    it = '0;
    it.data_byte = 8'hFF;
    send_request(it);
    it = '0;
    it.tile_first = 1'b1;
    send_request(it);
    it.tile_first = 1'b0;
    send_request(it);
    // Start and end on one byte: a short stream at once.
    it = '0;
    it.data_byte  = 8'hFF;
    it.tile_first = 1'b1;
    it.tile_end   = 1'b1;
    it.tile_pixels = 21'd5;
    send_request(it);
    // One tile per kind of split code: repeat, raw, fs of zero, largest fs.
    build_tile(3, 0, stream);
    send_tile(stream, 21'd3, 1);
    build_tile(1, RawCode, stream);
    send_tile(stream, 21'd1, 1);
    build_tile(2, 1, stream);
    send_tile(stream, 21'd2, 0);
    build_tile(1, 31, stream);
    send_tile(stream, 21'd1, 1);
    // Oversized tile counts saturate; a short header ends in a short stream.
    stream = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_tile(stream, 21'h1FFFFF, 0);
    stream = '{8'hFF, 8'h00};
    send_tile(stream, 21'h100000, 0);

    // Random part, one phase per block size, extremes and out-of-range
    // values included. Each phase starts from an idle block.
    sizes = '{32'd1, 32'd64, 32'd0, 32'd127, 32'($urandom_range(63, 2)), 32'd32};
    foreach (sizes[p]) begin
      drain();
      apb_write(AddrBlockSize, sizes[p]);
      @(posedge clk);
      sender_busy = ($urandom_range(2) == 0);
      while (bytes_sent < 30 + 50 * (p + 1)) begin
        send_random_tile();
        // Now and then, hold the input off until the output has caught up.
        if ($urandom_range(7) == 0) drain();
      end
      sender_busy = 0;
    end

    strm_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_rice_decoder_32bit_top: PASS");
    end else begin
      $display("tb_rice_decoder_32bit_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: rice_decoder_32bit_top.f
+incdir+design
design/rd32_pkg.sv
design/rd32_front.sv
design/rd32_queue.sv
design/rd32_back.sv
design/rice_decoder_32bit_top.sv
sim/tb_rice_decoder_32bit_top.sv
